@@ design/shsm_pkg.sv @@
// ----------------------------------------------------------------------------
// shsm_pkg: shared definitions for the half-step stepper mover
// Request kinds, register indexes, field widths, reset values and the
// coil sequence tables for both directions.
// ----------------------------------------------------------------------------
package shsm_pkg;

  // Field widths of the request, result and configuration registers.
  localparam int DEG_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int HOLD_W   = 10;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default number of eight-pattern cycles in one full turn.
  localparam int CYCLES_PER_TURN_DEF = 512;
  localparam int DEG_PER_TURN        = 360;
  // Fractional bits of the fixed-point constant that replaces the divide by 360.
  localparam int RECIP_SHIFT         = 25;

  // Reset values of the configuration registers.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1);
  localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(100);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_STOP = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD = 1'b0,
    CFG_HOLD        = 1'b1
  } cfg_idx_t;

  // Coil drive for one phase: bit0 A, bit1 B, bit2 C, bit3 D.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic cw,
                                                     input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] p;
    if (cw) begin
      case (idx)
        3'd0:    p = 4'b0001;
        3'd1:    p = 4'b0011;
        3'd2:    p = 4'b0010;
        3'd3:    p = 4'b0110;
        3'd4:    p = 4'b0100;
        3'd5:    p = 4'b1100;
        3'd6:    p = 4'b1000;
        3'd7:    p = 4'b1001;
        default: p = 4'b0000;
      endcase
    end else begin
      case (idx)
        3'd0:    p = 4'b1000;
        3'd1:    p = 4'b1100;
        3'd2:    p = 4'b0100;
        3'd3:    p = 4'b0110;
        3'd4:    p = 4'b0010;
        3'd5:    p = 4'b0011;
        3'd6:    p = 4'b0001;
        3'd7:    p = 4'b1001;
        default: p = 4'b0000;
      endcase
    end
    return p;
  endfunction

endpackage

@@ design/stepper_half_step_mover.sv @@
// A request is taken into an input register, and its result is then registered
// in the output register.
// One request per clock unless the output stalls; the state update is one
// short pass of counters, a constant multiply and a table lookup in between.
// Reset (rst_n low, synchronous): idle, coils off, direction clockwise,
// step period 1 ms and hold time 100 ms.
// ----------------------------------------------------------------------------
// stepper_half_step_mover: four-phase stepper half-step sequencer
// Turns the motor by an angle in half steps on millisecond ticks, holds the
// coils for a while after the move, and reports coils, busy and direction.
// ----------------------------------------------------------------------------
module stepper_half_step_mover #(
  parameter int CYCLES_PER_TURN = shsm_pkg::CYCLES_PER_TURN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // [0] clockwise, [16:1] degrees
  input  logic [shsm_pkg::KIND_W-1:0]     in_tuser,   // [1:0] kind
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [3:0] coils, [4] busy_res,
                                                      // [5] last_direction
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [shsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import shsm_pkg::*;

  // The turn count is N = CYCLES_PER_TURN * degrees / 360. The division is
  // replaced by a multiply with a rounded-up fixed-point reciprocal. The
  // rounding error times the largest angle stays below one unit of the
  // fraction, so the truncated product is exact for every 16-bit angle.
  localparam longint unsigned RECIP =
    ((longint'(CYCLES_PER_TURN) << RECIP_SHIFT) + DEG_PER_TURN - 1) / DEG_PER_TURN;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = DEG_W + RECIP_W;
  localparam int MAX_CYC = (CYCLES_PER_TURN * ((1 << DEG_W) - 1)) / DEG_PER_TURN;
  localparam int CYC_W   = $clog2(MAX_CYC + 1);
  // Eight half steps per cycle.
  localparam int HS_W    = CYC_W + PHASE_W;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STEP = 2'd1,
    MODE_HOLD = 2'd2
  } mode_t;

  // Configuration registers.
  logic [PERIOD_W-1:0] step_period_r;
  logic [HOLD_W-1:0]   hold_ms_r;

  // Input register.
  logic                s1_valid_r;
  logic [KIND_W-1:0]   s1_kind_r;
  logic                s1_cw_r;
  logic [DEG_W-1:0]    s1_deg_r;

  // Sequencer state.
  mode_t               mode_r, mode_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                moving_cw_r, moving_cw_nxt;
  logic [HS_W-1:0]     hs_left_r, hs_left_nxt;
  logic [PERIOD_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [HOLD_W-1:0]   hold_cnt_r, hold_cnt_nxt;
  logic [COIL_W-1:0]   coils_r, coils_nxt;
  logic                dir_r, dir_nxt;

  // Output register.
  logic                out_valid_r;
  logic [7:0]          out_data_r;

  logic                advance;
  logic [PROD_W-1:0]   prod;
  logic [CYC_W-1:0]    cycles;
  logic [HS_W-1:0]     hs_load;
  logic [HS_W-1:0]     hs_dec;
  logic [PERIOD_W-1:0] tick_inc;
  logic [HOLD_W-1:0]   hold_inc;

  // The pipeline moves whenever the output register is empty or being taken.
  // A request is accepted while the input register is empty or moving on.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Half steps for a move request.
  assign prod    = PROD_W'(s1_deg_r) * PROD_W'(RECIP);
  assign cycles  = prod[RECIP_SHIFT +: CYC_W];
  assign hs_load = {cycles, {PHASE_W{1'b0}}};

  assign hs_dec   = hs_left_r - HS_W'(1);
  assign tick_inc = tick_cnt_r + PERIOD_W'(1);
  assign hold_inc = hold_cnt_r + HOLD_W'(1);

  // Next state for the request in the input register. A tick counter that
  // reaches its limit or wraps to zero ends its interval; a zero period
  // behaves like one tick, and a zero hold time skips the hold.
  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    moving_cw_nxt = moving_cw_r;
    hs_left_nxt   = hs_left_r;
    tick_cnt_nxt  = tick_cnt_r;
    hold_cnt_nxt  = hold_cnt_r;
    coils_nxt     = coils_r;
    dir_nxt       = dir_r;
    case (s1_kind_r)
      KIND_MOVE: begin
        // A move is ignored unless the sequencer is idle.
        if (mode_r == MODE_IDLE) begin
          moving_cw_nxt = s1_cw_r;
          phase_nxt     = '0;
          tick_cnt_nxt  = '0;
          hs_left_nxt   = hs_load;
          if (hs_load == '0) begin
            // An angle too small for one cycle goes straight to holding, or to idle when the hold time is zero.
            hold_cnt_nxt = '0;
            if (hold_ms_r == '0) begin
              coils_nxt = '0;
              dir_nxt   = s1_cw_r;
              mode_nxt  = MODE_IDLE;
            end else begin
              mode_nxt = MODE_HOLD;
            end
          end else begin
            coils_nxt = coil_pattern(s1_cw_r, '0);
            mode_nxt  = MODE_STEP;
          end
        end
      end
      KIND_STOP: begin
        coils_nxt    = '0;
        mode_nxt     = MODE_IDLE;
        hs_left_nxt  = '0;
        tick_cnt_nxt = '0;
        hold_cnt_nxt = '0;
      end
      KIND_TICK: begin
        case (mode_r)
          MODE_STEP: begin
            tick_cnt_nxt = tick_inc;
            if (tick_inc >= step_period_r || tick_inc == '0) begin
              tick_cnt_nxt = '0;
              hs_left_nxt  = hs_dec;
              if (hs_dec == '0) begin
                hold_cnt_nxt = '0;
                if (hold_ms_r == '0) begin
                  coils_nxt = '0;
                  dir_nxt   = moving_cw_r;
                  mode_nxt  = MODE_IDLE;
                end else begin
                  mode_nxt = MODE_HOLD;
                end
              end else begin
                phase_nxt = phase_r + PHASE_W'(1);
                coils_nxt = coil_pattern(moving_cw_r, phase_r + PHASE_W'(1));
              end
            end
          end
          MODE_HOLD: begin
            hold_cnt_nxt = hold_inc;
            if (hold_inc >= hold_ms_r || hold_inc == '0) begin
              coils_nxt = '0;
              dir_nxt   = moving_cw_r;
              mode_nxt  = MODE_IDLE;
            end
          end
          default: begin
            // Ticks while idle change nothing.
          end
        endcase
      end
      default: begin
        // The unused kind code is ignored.
      end
    endcase
  end

  // Configuration registers. The user writes only while no request is in flight; not enforced by the block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= PERIOD_RST;
      hold_ms_r     <= HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_PERIOD: step_period_r <= cfg_data[PERIOD_W-1:0];
        CFG_HOLD:        hold_ms_r     <= cfg_data[HOLD_W-1:0];
        default:         ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_cw_r   <= in_tdata[0];
      s1_deg_r  <= in_tdata[DEG_W:1];
    end
  end

  // Sequencer state and output register. The state moves only when the
  // request in the input register is handed to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      phase_r     <= '0;
      moving_cw_r <= 1'b0;
      hs_left_r   <= '0;
      tick_cnt_r  <= '0;
      hold_cnt_r  <= '0;
      coils_r     <= '0;
      dir_r       <= 1'b1;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        mode_r      <= mode_nxt;
        phase_r     <= phase_nxt;
        moving_cw_r <= moving_cw_nxt;
        hs_left_r   <= hs_left_nxt;
        tick_cnt_r  <= tick_cnt_nxt;
        hold_cnt_r  <= hold_cnt_nxt;
        coils_r     <= coils_nxt;
        dir_r       <= dir_nxt;
        out_data_r  <= {2'b00, dir_nxt, (mode_nxt != MODE_IDLE), coils_nxt};
      end
    end
  end

endmodule
